// ----- sv/notch_phaser_wet_mix_core_defines.svh -----
// Assertion macros shared by the notch phaser wet mix RTL.
`ifndef NOTCH_PHASER_WET_MIX_CORE_DEFINES_SVH
`define NOTCH_PHASER_WET_MIX_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define NPWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define NPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/npwm_pkg.sv -----
// Shared types and constants of the notch phaser wet mix core.
`timescale 1ns / 1ps
package npwm_pkg;

	// Shared multiplier operand and accumulator widths
	localparam int OPW    = 21;
	localparam int PROD_W = 2 * OPW;
	localparam int ACC_W  = 56;

	localparam int HISTORY_LEN_DEF = 4;

	// 1.2 in Q1.16
	localparam int MIX_GAIN = 78643;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_ADDR_W-1:0] REG_TWO_COS  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_POLE_RSQ = 1'b1;

	typedef enum logic [1:0] {
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_mode_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_14,
		SH_16,
		SH_19
	} mac_shift_t;

	typedef struct packed {
		logic                   valid;
		mac_mode_t              mode;
		mac_shift_t             shift;
		logic signed [OPW-1:0]  opa;
		logic signed [OPW-1:0]  opb;
	} mac_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV,
		S_DIVW,
		S_WFIX,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_F5,
		S_F6,
		S_F7,
		S_F8,
		S_Y,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_M6,
		S_OUT
	} state_t;

endpackage

// ----- sv/npwm_mac.sv -----
// Shared multiply-accumulate unit: registered product, then shifted accumulate.
`timescale 1ns / 1ps
module npwm_mac
	import npwm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_op_t                  op,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	mac_mode_t                mode_s1;
	mac_shift_t               shift_s1;
	logic signed [ACC_W-1:0]  ext;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;

	// Register the product
	always_ff @(posedge clk) begin
		prod_s1 <= op.opa * op.opb;
	end

	// Carry the op control alongside the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			mode_s1  <= MAC_LOAD;
			shift_s1 <= SH_0;
		end else begin
			vld_s1   <= op.valid;
			mode_s1  <= op.mode;
			shift_s1 <= op.shift;
		end
	end

	// Align the product
	always_comb begin
		ext = ACC_W'(prod_s1);
		case (shift_s1)
			SH_0:    term = ext;
			SH_14:   term = ext <<< 14;
			SH_16:   term = ext <<< 16;
			SH_19:   term = ext <<< 19;
			default: term = ext;
		endcase
	end

	// Load, add or subtract into the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			case (mode_s1)
				MAC_LOAD: acc_q <= term;
				MAC_ADD:  acc_q <= acc_q + term;
				MAC_SUB:  acc_q <= acc_q - term;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

// ----- sv/notch_phaser_wet_mix_core.sv -----
// Top level: notch section with smoothed dry/wet mix, sequenced over one shared MAC.
// A sample runs the filter, mix and output states, after a wet update on frame start.
// No new sample is accepted before the output step ends, as the single shared
// multiply-accumulate unit with its two-stage pipeline performs all products in turn.
// A finished result waits in the output register while the next sample is accepted.
// Reset (arst_n low, asynchronous) clears filter delays, wet history and smoothed wet,
// and loads two_cos_coef = 0 and pole_radius_sq = 62467.
`timescale 1ns / 1ps
`include "notch_phaser_wet_mix_core_defines.svh"
module notch_phaser_wet_mix_core
	import npwm_pkg::*;
#(
	parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     sample_in,
	input  logic [15:0]            wet_target,
	input  logic                   frame_start,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [15:0]     sample_out
);

	localparam int SUM_W = $clog2((HISTORY_LEN + 1) * 65536);
	localparam int DivN  = HISTORY_LEN + 1;
	localparam logic [OPW-1:0] DIV_RECIP = OPW'((64'd1 << SUM_W) / DivN);
	localparam logic signed [ACC_W-1:0] RND_Y   = ACC_W'(1) <<< 29;
	localparam logic signed [ACC_W-1:0] RND_MIX = ACC_W'(1) <<< 30;

	state_t state_q, state_d;

	// Configuration registers
	logic signed [15:0] coef_c_q;
	logic [16:0]        d2_q;

	// Filter and wet state
	logic signed [15:0] x1_q, x2_q;
	logic signed [19:0] y1_q, y2_q;
	logic [15:0]        hist_q [HISTORY_LEN];
	logic [SUM_W-1:0]   hist_sum_q;
	logic [15:0]        w_q;

	// Latched input and scratch
	logic signed [15:0] x_q;
	logic [15:0]        target_q;
	logic               fs_q;
	logic signed [16:0] hi_q;
	logic signed [15:0] sample_out_q;
	logic               out_valid_q;

	// Datapath helpers
	mac_op_t                 op;
	logic signed [ACC_W-1:0] acc;
	logic [16:0]             a_coef;
	logic signed [16:0]      xsum;
	logic signed [17:0]      dry;
	logic [SUM_W-1:0]        sum_w;
	logic [15:0]             q_est;
	logic [SUM_W-1:0]        rem;
	logic [15:0]             w_new;
	logic signed [ACC_W-1:0] y_rnd;
	logic signed [19:0]      y_sat;
	logic signed [ACC_W-1:0] mix_rnd;
	logic signed [15:0]      mix_sat;
	logic                    out_free;

	npwm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	// Operand and result helpers
	assign a_coef   = 17'((18'(d2_q) + 18'h10000) >> 1);
	assign xsum     = 17'(x_q) + 17'(x2_q);
	assign dry      = $signed(18'h08000) - $signed({2'b00, w_q});
	assign sum_w    = hist_sum_q + SUM_W'(target_q);
	assign q_est    = acc[SUM_W+15:SUM_W];
	assign rem      = sum_w - SUM_W'(q_est * DivN);
	assign w_new    = q_est + 16'(rem >= SUM_W'(DivN));
	assign out_free = !out_valid_q || out_ready;

	// Round and saturate the filter output to 20 bits
	always_comb begin
		y_rnd = (acc + RND_Y) >>> 30;
		if ((&y_rnd[ACC_W-1:19]) || !(|y_rnd[ACC_W-1:19])) begin
			y_sat = y_rnd[19:0];
		end else if (y_rnd[ACC_W-1]) begin
			y_sat = 20'sh80000;
		end else begin
			y_sat = 20'sh7FFFF;
		end
	end

	// Round and saturate the mix to 16 bits
	always_comb begin
		mix_rnd = (acc + RND_MIX) >>> 31;
		if ((&mix_rnd[ACC_W-1:15]) || !(|mix_rnd[ACC_W-1:15])) begin
			mix_sat = mix_rnd[15:0];
		end else if (mix_rnd[ACC_W-1]) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = 16'sh7FFF;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = frame_start ? S_DIV : S_F1;
			S_DIV:   state_d = S_DIVW;
			S_DIVW:  state_d = S_WFIX;
			S_WFIX:  state_d = S_F1;
			S_F1:    state_d = S_F2;
			S_F2:    state_d = S_F3;
			S_F3:    state_d = S_F4;
			S_F4:    state_d = S_F5;
			S_F5:    state_d = S_F6;
			S_F6:    state_d = S_F7;
			S_F7:    state_d = S_F8;
			S_F8:    state_d = S_Y;
			S_Y:     state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = S_M4;
			S_M4:    state_d = S_M5;
			S_M5:    state_d = S_M6;
			S_M6:    state_d = S_OUT;
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Issue MAC ops per state
	always_comb begin
		op = '0;
		unique case (state_q)
			S_DIV: begin
				op = '{1'b1, MAC_LOAD, SH_0, DIV_RECIP, OPW'(sum_w)};
			end
			S_F1: begin
				op = '{1'b1, MAC_LOAD, SH_0, OPW'(coef_c_q), OPW'(y1_q)};
			end
			S_F2: begin
				op = '{1'b1, MAC_SUB, SH_0, OPW'(coef_c_q), OPW'(x1_q)};
			end
			S_F3: begin
				op = '{1'b1, MAC_ADD, SH_0, OPW'(16384), OPW'(xsum)};
			end
			S_F5: begin
				op = '{1'b1, MAC_LOAD, SH_0, OPW'(a_coef), OPW'(acc[18:0])};
			end
			S_F6: begin
				op = '{1'b1, MAC_ADD, SH_19, OPW'(a_coef), OPW'(hi_q)};
			end
			S_F7: begin
				op = '{1'b1, MAC_SUB, SH_14, OPW'({1'b0, d2_q}), OPW'(y2_q)};
			end
			S_M1: begin
				op = '{1'b1, MAC_LOAD, SH_0, OPW'({1'b0, w_q}), OPW'(y1_q)};
			end
			S_M3: begin
				op = '{1'b1, MAC_LOAD, SH_0, OPW'(MIX_GAIN), OPW'(acc[18:0])};
			end
			S_M4: begin
				op = '{1'b1, MAC_ADD, SH_19, OPW'(MIX_GAIN), OPW'(hi_q)};
			end
			S_M5: begin
				op = '{1'b1, MAC_ADD, SH_16, OPW'(dry), OPW'(x_q)};
			end
			default: begin
				op = '0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_c_q <= '0;
			d2_q     <= 17'd62467;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_TWO_COS:  coef_c_q <= $signed(cfg_wdata[15:0]);
				REG_POLE_RSQ: d2_q     <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// Latch the input transaction and the upper split of the accumulator
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			x_q      <= sample_in;
			target_q <= wet_target;
			fs_q     <= frame_start;
		end
		if (state_q == S_F5 || state_q == S_M3) begin
			hi_q <= acc[35:19];
		end
	end

	// Update wet smoothing and filter delays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= '0;
			hist_sum_q <= '0;
			for (int k = 0; k < HISTORY_LEN; k++) hist_q[k] <= '0;
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else begin
			if (state_q == S_WFIX) begin
				w_q        <= w_new;
				hist_sum_q <= hist_sum_q + SUM_W'(target_q) - SUM_W'(hist_q[HISTORY_LEN-1]);
				for (int k = HISTORY_LEN - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
				hist_q[0] <= target_q;
			end
			if (state_q == S_Y) begin
				y1_q <= y_sat;
				y2_q <= y1_q;
				x1_q <= x_q;
				x2_q <= x1_q;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			sample_out_q <= mix_sat;
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// Sequencer checks
	`NPWM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted sample did not start the sequence")
	`NPWM_ASSERT_SAME(a_result_from_out, $rose(out_valid), $past(state_q) == S_OUT, "result appeared outside the output step")
	`NPWM_ASSERT_NEXT(a_out_stall_holds, state_q == S_OUT && out_valid && !out_ready, state_q == S_OUT, "sequencer left output step while result was pending")
	`NPWM_ASSERT_NEXT(a_wet_only_on_frame, state_q != S_WFIX, $stable(w_q), "smoothed wet changed outside a frame start")
	`NPWM_ASSERT_SAME(a_frame_path, state_q == S_WFIX, fs_q, "wet update without frame start")

endmodule

// ----- verif/notch_phaser_wet_mix_checker.sv -----
// Checker: predicts every output transaction of the notch phaser wet mix core and compares it.
`timescale 1ns / 1ps
module notch_phaser_wet_mix_checker
	import npwm_pkg::*;
#(
	parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic signed [15:0]     sample_in,
	input  logic [15:0]            wet_target,
	input  logic                   frame_start,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic signed [15:0]     sample_out,
	output int                     fail_count,
	output int                     outstanding
);

	localparam longint Y_HI   = 524287;
	localparam longint Y_LO   = -524288;
	localparam longint OUT_HI = 32767;
	localparam longint OUT_LO = -32768;

	// Mirrored configuration
	longint two_cos;
	longint pole_rsq;

	// Mirrored filter and wet state
	longint x_d1, x_d2, y_d1, y_d2;
	logic [15:0] wet_hist [HISTORY_LEN];
	logic [15:0] wet_avg;

	logic signed [15:0] mix_expected [$];
	logic signed [15:0] want_mix;

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Run one sample through the notch section and the dry/wet mix, updating state
	function automatic logic signed [15:0] filter_and_mix(input logic signed [15:0] x_in,
			input logic [15:0] target, input logic fs);
		longint x, gain, tap_sum, acc, y, w, mix;
		int unsigned wsum;
		x = x_in;
		// Average the new target with the history on a frame start, then shift it in
		if (fs) begin
			wsum = target;
			for (int k = 0; k < HISTORY_LEN; k++)
				wsum += wet_hist[k];
			wet_avg = 16'(wsum / (HISTORY_LEN + 1));
			for (int k = HISTORY_LEN - 1; k > 0; k--)
				wet_hist[k] = wet_hist[k-1];
			wet_hist[0] = target;
		end
		// Notch section, exact in Q30, rounded half up, held to 20 bits
		gain    = (65536 + pole_rsq) >>> 1;
		tap_sum = x * 16384 - two_cos * x_d1 + x_d2 * 16384 + two_cos * y_d1;
		acc     = gain * tap_sum - pole_rsq * y_d2 * 16384;
		y       = (acc + (longint'(1) <<< 29)) >>> 30;
		if (y > Y_HI)
			y = Y_HI;
		else if (y < Y_LO)
			y = Y_LO;
		x_d2 = x_d1;
		x_d1 = x;
		y_d2 = y_d1;
		y_d1 = y;
		// Mix, exact in Q31, rounded half up, held to 16 bits
		w   = wet_avg;
		mix = MIX_GAIN * w * y + (32768 - w) * x * 65536;
		mix = (mix + (longint'(1) <<< 30)) >>> 31;
		if (mix > OUT_HI)
			mix = OUT_HI;
		else if (mix < OUT_LO)
			mix = OUT_LO;
		return 16'(mix);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_cos  = 0;
			pole_rsq = 62467;
			x_d1     = 0;
			x_d2     = 0;
			y_d1     = 0;
			y_d2     = 0;
			for (int k = 0; k < HISTORY_LEN; k++)
				wet_hist[k] = '0;
			wet_avg     = '0;
			mix_expected.delete();
			outstanding = 0;
		end else begin
			// Track register writes
			if (cfg_wr_en) begin
				if (cfg_addr == REG_TWO_COS)
					two_cos = $signed(cfg_wdata[15:0]);
				else if (cfg_addr == REG_POLE_RSQ)
					pole_rsq = cfg_wdata;
			end
			// Predict on each input transaction
			if (in_valid && in_ready)
				mix_expected.push_back(filter_and_mix(sample_in, wet_target, frame_start));
			// Compare each output transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (mix_expected.size() == 0) begin
					report_mismatch($sformatf("output %0d with nothing pending", sample_out));
				end else begin
					want_mix = mix_expected.pop_front();
					if (sample_out !== want_mix)
						report_mismatch($sformatf("sample_out %0d, predicted %0d",
							sample_out, want_mix));
				end
			end
			outstanding = mix_expected.size();
		end
	end

endmodule

// ----- verif/notch_phaser_wet_mix_core_tb.sv -----
// Testbench top: stimulus, register phases and verdict for the notch phaser wet mix core.
`timescale 1ns / 1ps
module notch_phaser_wet_mix_core_tb
	import npwm_pkg::*;
();

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int DIRECTED        = 20;
	localparam int SETTLE_CYCLES   = 24;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [15:0]     sample_in;
	logic [15:0]            wet_target;
	logic                   frame_start;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [15:0]     sample_out;

	int fail_count;
	int outstanding;
	bit steady;
	int frame_left;

	// Directed samples at the reset configuration: field extremes, wet above full,
	// frame start low between frames
	int dir_x [DIRECTED] = '{0, 32767, -32768, 32767, -32768, 1, -1, 32767, 32767, 32767,
		-32768, -32768, -32768, 0, 12345, -12345, 32767, -32768, 0, 0};
	int dir_w [DIRECTED] = '{0, 32768, 32768, 32768, 32768, 65535, 32769, 65535, 0, 0,
		32768, 32768, 0, 16384, 0, 32768, 43690, 21845, 32768, 0};
	bit dir_f [DIRECTED] = '{1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 1, 1, 1};

	// Register settings per phase; a negative radius means draw both at random
	int phase_cos [PHASES] = '{-27000, 32767, -32768, 8000, 0, 0, -32768, 0};
	int phase_rsq [PHASES] = '{64000, 65536, 0, 131071, 62467, -1, 131071, -1};

	notch_phaser_wet_mix_core #(
		.HISTORY_LEN(HISTORY_LEN_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.wet_target(wet_target),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out)
	);

	notch_phaser_wet_mix_checker #(
		.HISTORY_LEN(HISTORY_LEN_DEF)
	) mix_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.wet_target(wet_target),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none while steady
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			1, 2: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_wet();
		case ($urandom_range(0, 9))
			7: return 16'd32768;
			8: return 16'd0;
			9: return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// Present one sample and hold it until the input transaction completes
	task automatic push_sample(input logic [15:0] s, input logic [15:0] w, input logic fs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_in   = s;
		wet_target  = w;
		frame_start = fs;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_addr  = idx;
		cfg_wdata = val;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Drop valid, wait for every pending result, then let the pipeline settle
	task automatic drain();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Output side backpressure
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		logic fs;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_addr    = REG_TWO_COS;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		sample_in   = '0;
		wet_target  = '0;
		frame_start = 1'b0;
		steady      = 1'b0;
		frame_left  = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED; i++)
			push_sample(16'(dir_x[i]), 16'(dir_w[i]), dir_f[i]);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (phase_rsq[p] < 0) begin
				write_reg(REG_TWO_COS, CFG_DATA_W'($urandom));
				write_reg(REG_POLE_RSQ, CFG_DATA_W'($urandom_range(0, 131071)));
			end else begin
				write_reg(REG_TWO_COS, CFG_DATA_W'(phase_cos[p]));
				write_reg(REG_POLE_RSQ, CFG_DATA_W'(phase_rsq[p]));
			end
			// Run one phase back to back on both sides
			steady = (p == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Frames of random length, with an occasional stray frame start
				if (frame_left == 0) begin
					fs         = 1'b1;
					frame_left = $urandom_range(1, 12);
				end else begin
					fs = ($urandom_range(0, 19) == 0);
				end
				frame_left--;
				push_sample(rand_sample(), rand_wet(), fs);
			end
		end

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Run limit
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
